### src/elevator_dispatch_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Elevator dispatch controller assertion macros
// Shared property wrappers for the checker of the car controller.
// ----------------------------------------------------------------------------
`ifndef ELEVATOR_DISPATCH_CONTROLLER_UNIT_MACROS_SVH
`define ELEVATOR_DISPATCH_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EDC_ASSERT_NOW(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define EDC_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### src/edc_pkg.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller package
// Operation, direction and request-bit codes shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package edc_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef logic [2:0] req_t;

    localparam req_t REQ_UP    = 3'b001;
    localparam req_t REQ_DOWN  = 3'b010;
    localparam req_t REQ_CABIN = 3'b100;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the incoming beat
        logic commit;  // apply the captured beat to the car state
    } edc_cmd_t;

endpackage

### src/elevator_dispatch_controller_unit.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller unit
// Collective-control car controller for one elevator car.
// ----------------------------------------------------------------------------
//
// Channel   Handshake          Payload
// -------   ----------------   -------------------------------------------------
// command   start / busy       operation, floor_index, request_bits
// result    done (strobe)      current_floor, floor_number, run_state,
//                              door_open, target_floor
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Each beat is first captured into the beat registers; then, in the execute
// state, the datapath runs the nearest-above and nearest-below priority
// encoders over the floor store and commits the new car state. The done strobe
// is high for one cycle right after the commit, and busy is already low then,
// so the next beat can be taken in that same cycle. The receiver cannot stall;
// the result ports always show the car state, and reset clears all requests,
// puts the car idle at floor zero with the door closed.
//
`timescale 1ns / 1ps

module elevator_dispatch_controller_unit
    import edc_pkg::*;
#(
    parameter int NUM_FLOORS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [3:0]  floor_index,
    input  logic [2:0]  request_bits,
    output logic        done,
    output logic [3:0]  current_floor,
    output logic [4:0]  floor_number,
    output logic [1:0]  run_state,
    output logic        door_open,
    output logic [3:0]  target_floor
);

    // Command bundle from the sequencer into the datapath.
    edc_cmd_t cmd;

    // The sequencer owns the handshake and the result strobe.
    edc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the request store and the car state; its registers
    // drive the result ports directly.
    edc_datapath #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operation     (operation),
        .floor_index   (floor_index),
        .request_bits  (request_bits),
        .current_floor (current_floor),
        .floor_number  (floor_number),
        .run_state     (run_state),
        .door_open     (door_open),
        .target_floor  (target_floor)
    );

endmodule

### src/edc_ctrl.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller sequencer
// Two-state machine that captures a beat and then commits it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edc_ctrl
    import edc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output edc_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;

endmodule

### src/edc_datapath.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller datapath
// Request store, car state and the nearest-request searches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module edc_datapath
    import edc_pkg::*;
#(
    parameter int NUM_FLOORS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  edc_cmd_t    cmd,
    input  logic [1:0]  operation,
    input  logic [3:0]  floor_index,
    input  logic [2:0]  request_bits,
    output logic [3:0]  current_floor,
    output logic [4:0]  floor_number,
    output logic [1:0]  run_state,
    output logic        door_open,
    output logic [3:0]  target_floor
);

    localparam int FW = (NUM_FLOORS > 2) ? $clog2(NUM_FLOORS) : 1;

    // Captured beat.
    logic [1:0]    op_reg;
    logic [3:0]    fl_reg;
    req_t          bits_reg;

    // Car state.
    req_t          req_reg [NUM_FLOORS];
    req_t          req_next [NUM_FLOORS];
    logic [FW-1:0] car_reg;
    logic [FW-1:0] car_next;
    dir_t          dir_reg;
    dir_t          dir_next;
    logic          door_reg;
    logic          door_next;
    logic [FW-1:0] tgt_reg;
    logic [FW-1:0] tgt_next;

    logic [NUM_FLOORS-1:0] occ;
    logic [FW-1:0]         svc;
    req_t                  svc_req;
    logic                  at_top;
    logic                  at_bottom;
    logic                  ab_found;
    logic [FW-1:0]         ab_idx;
    logic                  bl_found;
    logic [FW-1:0]         bl_idx;
    logic                  going_up;
    logic                  ahead_found;
    logic [FW-1:0]         ahead_idx;
    logic                  back_found;
    logic [FW-1:0]         back_idx;
    req_t                  same_mask;
    req_t                  other_mask;
    logic [FW+3:0]         fl_ext;
    logic [FW-1:0]         fl_idx;
    logic                  fl_ok;
    logic [FW+7:0]         car_ext;
    logic [FW+7:0]         tgt_ext;
    logic [7:0]            shown;

    // Floor the tick looks at: the car floor when idle, else the floor reached.
    always_comb
    begin
        unique case (dir_reg)
            DIR_UP:   svc = car_reg + FW'(1);
            DIR_DOWN: svc = car_reg - FW'(1);
            default:  svc = car_reg;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            occ[i] = |req_reg[i];
        end
    end

    always_comb
    begin
        svc_req = '0;
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (FW'(i) == svc)
            begin
                svc_req = req_reg[i];
            end
        end
    end

    // Nearest occupied floor above the service floor (lowest hit wins).
    always_comb
    begin
        ab_found = 1'b0;
        ab_idx   = '0;
        for (int i = NUM_FLOORS - 1; i >= 0; i--)
        begin
            if (occ[i] && (FW'(i) > svc))
            begin
                ab_found = 1'b1;
                ab_idx   = FW'(i);
            end
        end
    end

    // Nearest occupied floor below the service floor (highest hit wins).
    always_comb
    begin
        bl_found = 1'b0;
        bl_idx   = '0;
        for (int i = 0; i < NUM_FLOORS; i++)
        begin
            if (occ[i] && (FW'(i) < svc))
            begin
                bl_found = 1'b1;
                bl_idx   = FW'(i);
            end
        end
    end

    assign at_top    = ({1'b0, car_reg} + (FW+1)'(1)) >= (FW+1)'(NUM_FLOORS);
    assign at_bottom = (car_reg == '0);

    assign going_up    = (dir_reg == DIR_UP);
    assign ahead_found = going_up ? ab_found : bl_found;
    assign ahead_idx   = going_up ? ab_idx   : bl_idx;
    assign back_found  = going_up ? bl_found : ab_found;
    assign back_idx    = going_up ? bl_idx   : ab_idx;
    assign same_mask   = going_up ? (REQ_UP | REQ_CABIN) : (REQ_DOWN | REQ_CABIN);
    assign other_mask  = going_up ? REQ_DOWN : REQ_UP;

    assign fl_ext = {{FW{1'b0}}, fl_reg};
    assign fl_idx = fl_ext[FW-1:0];
    assign fl_ok  = ({28'd0, fl_reg} < 32'(NUM_FLOORS));

    always_comb
    begin
        req_next  = req_reg;
        car_next  = car_reg;
        dir_next  = dir_reg;
        door_next = door_reg;
        tgt_next  = tgt_reg;
        case (op_reg)
            OP_TICK:
            begin
                if (!door_reg)
                begin
                    unique case (dir_reg)
                        DIR_IDLE:
                        begin
                            if (svc_req != '0)
                            begin
                                req_next[svc] = '0;
                                door_next     = 1'b1;
                            end
                            else if (ab_found)
                            begin
                                tgt_next = ab_idx;
                                dir_next = DIR_UP;
                            end
                            else
                            begin
                                tgt_next = bl_idx;
                                if (bl_found)
                                begin
                                    dir_next = DIR_DOWN;
                                end
                            end
                        end
                        DIR_UP, DIR_DOWN:
                        begin
                            if ((going_up && at_top) || (!going_up && at_bottom))
                            begin
                                dir_next = DIR_IDLE;
                            end
                            else
                            begin
                                car_next = svc;
                                if ((svc_req & same_mask) != '0)
                                begin
                                    // Stop for a call in the travel direction.
                                    req_next[svc] = svc_req & ~same_mask;
                                    door_next     = 1'b1;
                                    tgt_next      = ahead_idx;
                                    if (!ahead_found)
                                    begin
                                        dir_next = DIR_IDLE;
                                    end
                                end
                                else if ((svc_req != '0) && !ahead_found)
                                begin
                                    // Last call this way: serve it and reverse, or go idle if no call lies behind.
                                    req_next[svc] = svc_req & ~other_mask;
                                    door_next     = 1'b1;
                                    tgt_next      = back_idx;
                                    if (!back_found)
                                    begin
                                        dir_next = DIR_IDLE;
                                    end
                                    else if (going_up)
                                    begin
                                        dir_next = DIR_DOWN;
                                    end
                                    else
                                    begin
                                        dir_next = DIR_UP;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            dir_next = dir_reg;
                        end
                    endcase
                end
            end
            OP_ADD:
            begin
                if (fl_ok)
                begin
                    req_next[fl_idx] = req_reg[fl_idx] | bits_reg;
                end
            end
            OP_CLOSE:
            begin
                door_next = 1'b0;
            end
            default:
            begin
                door_next = door_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            fl_reg   <= floor_index;
            bits_reg <= request_bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FLOORS; i++)
            begin
                req_reg[i] <= '0;
            end
            car_reg  <= '0;
            dir_reg  <= DIR_IDLE;
            door_reg <= 1'b0;
            tgt_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            req_reg  <= req_next;
            car_reg  <= car_next;
            dir_reg  <= dir_next;
            door_reg <= door_next;
            tgt_reg  <= tgt_next;
        end
    end

    // Displayed number skips floor zero.
    assign car_ext = {8'd0, car_reg};
    assign tgt_ext = {8'd0, tgt_reg};
    assign shown   = (car_ext[7:0] <= 8'd2) ? (car_ext[7:0] - 8'd3) : (car_ext[7:0] - 8'd2);

    assign current_floor = car_ext[3:0];
    assign floor_number  = shown[4:0];
    assign run_state     = dir_reg;
    assign door_open     = door_reg;
    assign target_floor  = tgt_ext[3:0];

endmodule

### src/edc_checker.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller checker
// Port-level timing checks, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "elevator_dispatch_controller_unit_macros.svh"

module edc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [3:0] current_floor,
    input logic [1:0] run_state
);

    // An accepted beat makes the unit busy for exactly one cycle.
    `EDC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted beat not busy")
    `EDC_ASSERT_NEXT(a_busy_one, clk, rst_n, busy, !busy && done, "busy cycle without strobe")
    // No strobe without a preceding busy cycle.
    `EDC_ASSERT_NEXT(a_no_spurious, clk, rst_n, !busy, !done, "strobe without a beat")
    // Car state only changes with a strobe.
    `EDC_ASSERT_NOW(a_state_hold, clk, rst_n, !done,
        $stable(current_floor) && $stable(run_state), "car state changed without strobe")

endmodule

bind elevator_dispatch_controller_unit edc_checker u_edc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .current_floor (current_floor),
    .run_state     (run_state)
);

### tb/sv/elevator_dispatch_controller_unit_checker.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller result checker
// Watches the command and result channels of the car controller. It keeps its
// own copy of the car state, works out the report that each command beat must
// produce, and compares every result beat against the oldest pending report.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elevator_dispatch_controller_unit_checker
    import edc_pkg::*;
#(
    parameter int NUM_FLOORS = 11
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  operation,
    input  logic [3:0]  floor_index,
    input  logic [2:0]  request_bits,
    input  logic        done,
    input  logic [3:0]  current_floor,
    input  logic [4:0]  floor_number,
    input  logic [1:0]  run_state,
    input  logic        door_open,
    input  logic [3:0]  target_floor,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [3:0] cur_floor;
        logic [4:0] number;
        logic [1:0] state;
        logic       door;
        logic [3:0] target;
    } car_report_t;

    // Predicted car state.
    logic [2:0]  floor_calls [NUM_FLOORS];
    logic [3:0]  car_at;
    dir_t        heading;
    logic        door_flag;
    logic [3:0]  aim;

    car_report_t expected_reports [$];

    // Nearest floor above with any call; hit is zero when there is none.
    function automatic logic nearest_above(input logic [3:0] from, output logic [3:0] hit);
        logic found;
        found = 1'b0;
        hit = '0;
        for (int i = NUM_FLOORS - 1; i > int'(from); i--)
        begin
            if (floor_calls[i] != '0)
            begin
                hit = 4'(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Nearest floor below with any call; floor zero counts as a hit.
    function automatic logic nearest_below(input logic [3:0] from, output logic [3:0] hit);
        logic found;
        found = 1'b0;
        hit = '0;
        for (int i = 0; i < int'(from) && i < NUM_FLOORS; i++)
        begin
            if (floor_calls[i] != '0)
            begin
                hit = 4'(i);
                found = 1'b1;
            end
        end
        return found;
    endfunction

    // Stop and reversal rules once the car has moved onto a new floor.
    function automatic void arrive_at_floor(input logic going_up);
        logic [2:0] same_bit;
        logic [2:0] other_bit;
        logic [2:0] calls;
        logic [3:0] hit;
        logic       found;
        same_bit  = going_up ? REQ_UP : REQ_DOWN;
        other_bit = going_up ? REQ_DOWN : REQ_UP;
        calls     = floor_calls[car_at];
        if ((calls & (same_bit | REQ_CABIN)) != '0)
        begin
            floor_calls[car_at] = calls & ~(same_bit | REQ_CABIN);
            door_flag = 1'b1;
            if (going_up)
                found = nearest_above(car_at, hit);
            else
                found = nearest_below(car_at, hit);
            aim = hit;
            if (!found)
                heading = DIR_IDLE;
        end
        else if (calls != '0)
        begin
            if (going_up)
                found = nearest_above(car_at, hit);
            else
                found = nearest_below(car_at, hit);
            if (!found)
            begin
                floor_calls[car_at] = calls & ~other_bit;
                door_flag = 1'b1;
                if (going_up)
                    found = nearest_below(car_at, hit);
                else
                    found = nearest_above(car_at, hit);
                aim = hit;
                if (!found)
                    heading = DIR_IDLE;
                else if (going_up)
                    heading = DIR_DOWN;
                else
                    heading = DIR_UP;
            end
        end
    endfunction

    // Applies one command beat to the predicted state and returns the report.
    function automatic car_report_t predict_car_report(input logic [1:0] op,
                                                       input logic [3:0] fl,
                                                       input logic [2:0] bits);
        car_report_t rpt;
        logic [3:0]  hit;
        int          shown;
        if (op == OP_TICK)
        begin
            if (!door_flag)
            begin
                case (heading)
                    DIR_IDLE:
                    begin
                        if (floor_calls[car_at] != '0)
                        begin
                            floor_calls[car_at] = '0;
                            door_flag = 1'b1;
                        end
                        else if (nearest_above(car_at, hit))
                        begin
                            aim = hit;
                            heading = DIR_UP;
                        end
                        else
                        begin
                            if (nearest_below(car_at, hit))
                                heading = DIR_DOWN;
                            aim = hit;
                        end
                    end
                    DIR_UP:
                    begin
                        if (int'(car_at) + 1 >= NUM_FLOORS)
                            heading = DIR_IDLE;
                        else
                        begin
                            car_at = car_at + 4'd1;
                            arrive_at_floor(1'b1);
                        end
                    end
                    DIR_DOWN:
                    begin
                        if (car_at == '0)
                            heading = DIR_IDLE;
                        else
                        begin
                            car_at = car_at - 4'd1;
                            arrive_at_floor(1'b0);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (op == OP_ADD)
        begin
            if (int'(fl) < NUM_FLOORS)
                floor_calls[fl] = floor_calls[fl] | bits;
        end
        else if (op == OP_CLOSE)
        begin
            door_flag = 1'b0;
        end

        // The display skips floor zero.
        shown = int'(car_at) - 2;
        if (shown <= 0)
            shown = shown - 1;
        rpt.cur_floor = car_at;
        rpt.number    = shown[4:0];
        rpt.state     = heading;
        rpt.door      = door_flag;
        rpt.target    = aim;
        return rpt;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        car_report_t want;
        car_report_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_FLOORS; i++)
                floor_calls[i] = '0;
            car_at    = '0;
            heading   = DIR_IDLE;
            door_flag = 1'b0;
            aim       = '0;
            expected_reports.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // The result of an older beat is handled before a new beat is taken.
            if (done)
            begin
                got = {current_floor, floor_number, run_state, door_open, target_floor};
                if (expected_reports.size() == 0)
                begin
                    $error("result beat with no command beat waiting for it");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (got.cur_floor !== want.cur_floor)
                    begin
                        $error("current_floor: expected %0d, actual %0d",
                               want.cur_floor, got.cur_floor);
                        fail_count++;
                    end
                    if (got.number !== want.number)
                    begin
                        $error("floor_number: expected %0d, actual %0d",
                               $signed(want.number), $signed(got.number));
                        fail_count++;
                    end
                    if (got.state !== want.state)
                    begin
                        $error("run_state: expected %0d, actual %0d",
                               want.state, got.state);
                        fail_count++;
                    end
                    if (got.door !== want.door)
                    begin
                        $error("door_open: expected %0d, actual %0d",
                               want.door, got.door);
                        fail_count++;
                    end
                    if (got.target !== want.target)
                    begin
                        $error("target_floor: expected %0d, actual %0d",
                               want.target, got.target);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_reports.push_back(predict_car_report(operation, floor_index,
                                                              request_bits));
            pending = expected_reports.size();
        end
    end

endmodule

### tb/sv/elevator_dispatch_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// Elevator dispatch controller testbench
// Drives command beats into the car controller, a short directed walk through
// the stop, reversal and lowest-floor rules first and then a long random mix,
// while a checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elevator_dispatch_controller_unit_tb;
    import edc_pkg::*;

    localparam int NUM_FLOORS   = 11;
    localparam int RANDOM_BEATS = 1200;
    // The slowest legal run is roughly 1250 beats, each followed at worst by the
    // longest sender gap, so this limit leaves a wide margin.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles to linger once nothing is outstanding.
    localparam int DRAIN_CYCLES = 10;
    // Operation code 3 has no meaning to the block and must change nothing.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [3:0]  floor_index;
    logic [2:0]  request_bits;
    logic        done;
    logic [3:0]  current_floor;
    logic [4:0]  floor_number;
    logic [1:0]  run_state;
    logic        door_open;
    logic [3:0]  target_floor;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    // While set, the sender puts beats back to back with no gaps at all.
    bit          burst_mode = 1'b0;

    elevator_dispatch_controller_unit #(
        .NUM_FLOORS    (NUM_FLOORS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .floor_index   (floor_index),
        .request_bits  (request_bits),
        .done          (done),
        .current_floor (current_floor),
        .floor_number  (floor_number),
        .run_state     (run_state),
        .door_open     (door_open),
        .target_floor  (target_floor)
    );

    // The checker sees the same pins as the block and reports how many
    // mismatches it found and how many results are still outstanding.
    elevator_dispatch_controller_unit_checker #(
        .NUM_FLOORS    (NUM_FLOORS)
    ) u_report_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .floor_index   (floor_index),
        .request_bits  (request_bits),
        .done          (done),
        .current_floor (current_floor),
        .floor_number  (floor_number),
        .run_state     (run_state),
        .door_open     (door_open),
        .target_floor  (target_floor),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 12 ns clock period.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Presents one command beat at a falling edge and holds it until the
    // block takes it, i.e. until a rising edge where busy is low. Returns at
    // the next falling edge with start still high, so a following beat can
    // go out back to back without start ever dropping.
    task automatic send_beat(input logic [1:0] op, input logic [3:0] fl,
                             input logic [2:0] bits);
        operation    = op;
        floor_index  = fl;
        request_bits = bits;
        start        = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Mostly no gap, often a short one, now and then a long one. The short
    // gaps land on both the capture and the commit step of the block's work.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Sends a beat and then lets the sender sit idle for a random while.
    task automatic issue(input logic [1:0] op, input logic [3:0] fl,
                         input logic [2:0] bits);
        int gap;
        send_beat(op, fl, bits);
        gap = pick_gap();
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random beats are weighted towards sequences that keep the car moving:
    // ticks dominate, requests come often, and door-closed events are common
    // enough that an open door rarely stalls travel for long. A few beats are
    // noise: the unused operation and requests for floors that do not exist.
    task automatic issue_random_beat();
        int         roll;
        logic [1:0] op;
        logic [3:0] fl;
        logic [2:0] bits;
        roll = $urandom_range(0, 99);
        fl   = 4'($urandom_range(0, 15));
        bits = 3'($urandom_range(0, 7));
        if (roll < 2)
            op = OP_UNUSED;
        else if (roll < 48)
            op = OP_TICK;
        else if (roll < 74)
        begin
            op = OP_ADD;
            if ($urandom_range(0, 99) < 95)
                fl = 4'($urandom_range(0, NUM_FLOORS - 1));
        end
        else
            op = OP_CLOSE;
        issue(op, fl, bits);
    endtask

    initial
    begin
        // Every input is known from time zero on.
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_TICK;
        floor_index  = '0;
        request_bits = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walk. A tick on an empty building finds nothing, the
        // unused operation and out-of-range floors must leave no trace, and
        // a request at the car's own floor is served in place.
        issue(OP_TICK, 4'd0, 3'd0);
        issue(OP_UNUSED, 4'd15, 3'd7);
        issue(OP_ADD, 4'd15, 3'd7);
        issue(OP_ADD, 4'd11, 3'd7);
        issue(OP_ADD, 4'd0, REQ_UP);
        issue(OP_TICK, 4'd0, 3'd0);
        // The door is open, so this tick must do nothing.
        issue(OP_TICK, 4'd0, 3'd0);
        issue(OP_CLOSE, 4'd0, 3'd0);

        // Going up, the car passes a down call at floor one because a cabin
        // call waits above it, then stops at floor three and goes idle.
        issue(OP_ADD, 4'd1, REQ_DOWN);
        issue(OP_ADD, 4'd3, REQ_CABIN);
        repeat (4) issue(OP_TICK, 4'd0, 3'd0);

        // A call at the lowest floor must be found by the search below. The
        // car heads down, serves floor one on the way and keeps going.
        issue(OP_ADD, 4'd0, REQ_CABIN);
        issue(OP_CLOSE, 4'd0, 3'd0);
        repeat (3) issue(OP_TICK, 4'd0, 3'd0);
        issue(OP_CLOSE, 4'd0, 3'd0);
        issue(OP_TICK, 4'd0, 3'd0);
        issue(OP_CLOSE, 4'd0, 3'd0);

        // Send the car off towards the top floor; the random part takes over.
        issue(OP_ADD, 4'(NUM_FLOORS - 1), REQ_UP | REQ_CABIN);
        issue(OP_TICK, 4'd0, 3'd0);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            // The last fifth of every 300 beats is sent back to back.
            burst_mode = (n % 300) >= 240;
            // Halfway through, hold off until the block has answered
            // everything that is outstanding.
            if (n == RANDOM_BEATS / 2)
            begin
                start = 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            issue_random_beat();
        end
        start = 1'b0;

        // Wait for the last results, then a little longer so that any stray
        // result beat is still caught by the checker.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
